### src/dfd_pkg.sv
package dfd_pkg;

  localparam int WORD_W  = 32;
  localparam int INDEX_W = 4;
  localparam int BYTE_W  = 8;
  localparam int COUNT_W = 7;
  localparam int CC_W    = 5;

  localparam logic [COUNT_W-1:0] COUNT_MAX = 7'd127;
  localparam logic [CC_W-1:0]    CC_RESET  = 5'd12;

  // Tail bytes in arrival order: 00 00 80 7F.
  localparam logic [BYTE_W-1:0] TAIL_B0 = 8'h00;
  localparam logic [BYTE_W-1:0] TAIL_B1 = 8'h00;
  localparam logic [BYTE_W-1:0] TAIL_B2 = 8'h80;
  localparam logic [BYTE_W-1:0] TAIL_B3 = 8'h7F;

  // Contents of one output word cell.
  typedef struct packed {
    logic               valid;
    logic [INDEX_W-1:0] index;
    logic               last;
    logic [WORD_W-1:0]  word;
  } word_cell_t;

  // Status of the byte history toward the top level.
  typedef struct packed {
    logic frame_due;  // the next byte, if it closes a tail, emits a frame
    logic load;       // the accepted byte closed a tail that emits a frame
  } hist_status_t;

endpackage

### src/dfd_history.sv
module dfd_history #(
  parameter int MAX_CHANNELS = 16,
  localparam int HistDepth = 4 * MAX_CHANNELS + 3
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                accept,
  input  logic [dfd_pkg::BYTE_W-1:0]          data_byte,
  input  logic [dfd_pkg::CC_W-1:0]            n_eff,
  output logic [dfd_pkg::BYTE_W-1:0]          hist [HistDepth],
  output dfd_pkg::hist_status_t               status
);

  logic [dfd_pkg::COUNT_W-1:0] count;
  logic [dfd_pkg::COUNT_W-1:0] count_inc;
  logic [dfd_pkg::COUNT_W-1:0] threshold;
  logic                        tail_match;

  // Byte cells: each takes its neighbor's byte on every accepted transaction.
  always_ff @(posedge clk) begin
    if (accept) begin
      hist[0] <= data_byte;
      for (int i = 1; i < HistDepth; i++) begin
        hist[i] <= hist[i-1];
      end
    end
  end

  assign count_inc = (count == dfd_pkg::COUNT_MAX) ? count : count + 7'd1;
  assign threshold = {n_eff, 2'b00} + 7'd4;

  assign tail_match = (count_inc >= 7'd4) &&
                      (hist[2] == dfd_pkg::TAIL_B0) &&
                      (hist[1] == dfd_pkg::TAIL_B1) &&
                      (hist[0] == dfd_pkg::TAIL_B2) &&
                      (data_byte == dfd_pkg::TAIL_B3);

  assign status.frame_due = (n_eff != '0) && (count_inc >= threshold);
  assign status.load      = accept && tail_match && status.frame_due;

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (accept) begin
      count <= tail_match ? '0 : count_inc;
    end
  end

endmodule

### src/dfd_word_cell.sv
module dfd_word_cell (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 load,
  input  dfd_pkg::word_cell_t  load_cell,
  input  logic                 shift,
  input  dfd_pkg::word_cell_t  from_next,
  output dfd_pkg::word_cell_t  cell_q
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cell_q <= '0;
    end else if (load) begin
      cell_q <= load_cell;
    end else if (shift) begin
      cell_q <= from_next;
    end
  end

endmodule

### src/tail_framed_float_deframer_unit.sv
// The first word of a frame is valid in the cycle after the tail's last byte is taken.
// Unstalled throughput: one byte per cycle in; one channel word per cycle out of the chain.
// Input is stalled only while the chain still drains and the next byte could close a frame.
// Reset (rst, synchronous, active high) empties the chain, clears the byte count and
// restores channel_count to 12; the history bytes themselves are not cleared.
module tail_framed_float_deframer_unit #(
  parameter int MAX_CHANNELS = 16
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [dfd_pkg::CC_W-1:0]      cfg_data,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [dfd_pkg::BYTE_W-1:0]    data_byte,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [dfd_pkg::WORD_W-1:0]    channel_word,
  output logic [dfd_pkg::INDEX_W-1:0]   channel_index,
  output logic                          last_word
);

  localparam int HistDepth = 4 * MAX_CHANNELS + 3;
  localparam int SlotIdxW  = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;

  logic [dfd_pkg::CC_W-1:0]   channel_count;
  logic [dfd_pkg::CC_W-1:0]   n_eff;
  logic                       in_accept;
  logic                       out_shift;
  logic                       chain_busy;
  logic [dfd_pkg::BYTE_W-1:0] hist [HistDepth];
  dfd_pkg::hist_status_t      status;
  logic [dfd_pkg::WORD_W-1:0] slot_word [MAX_CHANNELS];
  dfd_pkg::word_cell_t        cells [MAX_CHANNELS];

  // Always writable, so the user must write the config register only while idle.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      channel_count <= dfd_pkg::CC_RESET;
    end else if (cfg_valid && cfg_ready) begin
      channel_count <= cfg_data;
    end
  end

  // Counts above the number of cells are clamped to the chain length.
  assign n_eff = (channel_count > 5'(MAX_CHANNELS)) ? 5'(MAX_CHANNELS) : channel_count;

  // The chain is busy while its head cell holds a word. A new frame can only be loaded
  // into an empty chain, so the input is held off when the next byte could close a frame.
  assign chain_busy = cells[0].valid;
  assign in_stall   = chain_busy && status.frame_due;
  assign in_accept  = in_valid && !in_stall;

  dfd_history #(
    .MAX_CHANNELS (MAX_CHANNELS)
  ) u_history (
    .clk       (clk),
    .rst       (rst),
    .accept    (in_accept),
    .data_byte (data_byte),
    .n_eff     (n_eff),
    .hist      (hist),
    .status    (status)
  );

  // Slot j holds the word that sits j+1 words before the tail. Positions refer to the
  // history before the tail byte shifts in, so each byte sits one place nearer the head.
  // The earliest byte of a word is its least significant byte.
  generate
    for (genvar j = 0; j < MAX_CHANNELS; j++) begin : g_slot
      assign slot_word[j] = {hist[4*j+3], hist[4*j+4], hist[4*j+5], hist[4*j+6]};
    end
  endgenerate

  assign out_shift = out_valid && !out_stall;

  // Word cell i receives channel i of the frame at load time and then hands its contents
  // to cell i-1 on every completed output transaction; cell 0 drives the output.
  generate
    for (genvar i = 0; i < MAX_CHANNELS; i++) begin : g_cell
      logic [dfd_pkg::CC_W-1:0] slot_idx;
      dfd_pkg::word_cell_t      load_cell;
      dfd_pkg::word_cell_t      from_next;

      assign slot_idx = n_eff - 5'(i) - 5'd1;

      always_comb begin
        load_cell.valid = (5'(i) < n_eff);
        load_cell.index = 4'(i);
        load_cell.last  = ((5'(i) + 5'd1) == n_eff);
        load_cell.word  = load_cell.valid ? slot_word[slot_idx[SlotIdxW-1:0]] : '0;
      end

      if (i == MAX_CHANNELS - 1) begin : g_end
        assign from_next = '0;
      end else begin : g_mid
        assign from_next = cells[i+1];
      end

      dfd_word_cell u_cell (
        .clk       (clk),
        .rst       (rst),
        .load      (status.load),
        .load_cell (load_cell),
        .shift     (out_shift),
        .from_next (from_next),
        .cell_q    (cells[i])
      );
    end
  endgenerate

  assign out_valid     = cells[0].valid;
  assign channel_word  = cells[0].word;
  assign channel_index = cells[0].index;
  assign last_word     = cells[0].last;

  // A frame is only ever loaded into an empty chain.
  assert property (@(posedge clk) disable iff (rst) status.load |-> !chain_busy)
    else $error("frame loaded while the word chain still holds words");

  // Loading a frame presents its first word in the next cycle.
  assert property (@(posedge clk) disable iff (rst) status.load |=> (out_valid && channel_index == '0))
    else $error("loaded frame does not present channel zero");

  // The input is held off only while the chain drains.
  assert property (@(posedge clk) disable iff (rst) in_stall |-> chain_busy)
    else $error("input stalled with an empty word chain");

  // Valid words stay packed toward the head of the chain.
  generate
    for (genvar a = 1; a < MAX_CHANNELS; a++) begin : g_pack_chk
      assert property (@(posedge clk) disable iff (rst) cells[a].valid |-> cells[a-1].valid)
        else $error("gap in the word chain");
    end
  endgenerate

endmodule

### dv/tail_framed_float_deframer_unit_test.sv
`timescale 1ns / 100ps

// Byte-stream test of the tail-framed float deframer. A driver feeds received bytes
// through the valid/stall input channel, and a monitor takes channel words from the
// output channel. Every accepted byte also goes through a local model of the frame
// parser, and the channel words that model predicts are queued for the monitor.
module tail_framed_float_deframer_unit_test;

  localparam int WORD_W  = dfd_pkg::WORD_W;
  localparam int INDEX_W = dfd_pkg::INDEX_W;
  localparam int BYTE_W  = dfd_pkg::BYTE_W;
  localparam int COUNT_W = dfd_pkg::COUNT_W;
  localparam int CC_W    = dfd_pkg::CC_W;

  localparam int MAX_CH        = 16;
  localparam int HIST_LEN      = MAX_CH * 4 + 4;
  localparam int SETTLE_CYCLES = 8;
  localparam int PHASES        = 8;
  localparam int PHASE_BUDGET  = 12;
  localparam int LONG_RUN      = 124;

  // One predicted channel word, with the fields that the output port carries.
  typedef struct {
    logic [WORD_W-1:0]  word;
    logic [INDEX_W-1:0] index;
    logic               last;
  } channel_word_t;

  logic                clk           = 1'b0;
  logic                rst           = 1'b1;
  logic                cfg_valid     = 1'b0;
  logic                cfg_ready;
  logic [CC_W-1:0]     cfg_data      = '0;
  logic                in_valid      = 1'b0;
  logic                in_stall;
  logic [BYTE_W-1:0]   data_byte     = '0;
  logic                out_valid;
  logic                out_stall     = 1'b0;
  logic [WORD_W-1:0]   channel_word;
  logic [INDEX_W-1:0]  channel_index;
  logic                last_word;

  // Bytes waiting for the driver, and channel words waiting for the monitor.
  logic [BYTE_W-1:0]   pending_bytes [$];
  channel_word_t       expected_words [$];
  channel_word_t       head_word;

  // Local copy of the parser state: byte history (newest at 0), the saturating
  // count of bytes since the last tail, and the channel count register.
  logic [BYTE_W-1:0]   hist_bytes [0:HIST_LEN-1];
  logic [COUNT_W-1:0]  since_tail;
  logic [CC_W-1:0]     channel_count;

  int send_idle_pct   = 0;
  int recv_stall_pct  = 0;
  int bytes_queued    = 0;
  int bytes_taken     = 0;
  int words_checked   = 0;
  int frames_checked  = 0;
  int settings_used   = 0;
  int mismatch_count  = 0;

  // Channel counts and idle rates of the random phases. The zero count and a count
  // above the frame limit are both in the list, as are the smallest and largest
  // legal counts and the reset value.
  int phase_cc   [PHASES] = '{1, 4, 16, 2, 0, 31, 3, 12};
  int phase_send [PHASES] = '{0, 61, 0, 18, 0, 61, 0, 18};
  int phase_recv [PHASES] = '{0, 0, 61, 18, 0, 0, 61, 18};

  tail_framed_float_deframer_unit #(
    .MAX_CHANNELS (MAX_CH)
  ) u_top (
    .clk           (clk),
    .rst           (rst),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_data      (cfg_data),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .data_byte     (data_byte),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .channel_word  (channel_word),
    .channel_index (channel_index),
    .last_word     (last_word)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  task automatic report_mismatch(input string msg);
    $display("MISMATCH at %0t: %s", $realtime, msg);
    mismatch_count++;
  endtask

  function automatic void clear_parser_model();
    for (int i = 0; i < HIST_LEN; i++) hist_bytes[i] = '0;
    since_tail    = '0;
    channel_count = dfd_pkg::CC_RESET;
  endfunction

  // Shifts one accepted byte into the history. When the newest four bytes form the
  // tail and all of them came after the previous tail, the tail is consumed, and a
  // long enough payload before it yields one little-endian word per channel.
  function automatic void take_byte(input logic [BYTE_W-1:0] b);
    int            nch;
    int            payload_len;
    int            pos;
    channel_word_t cw;
    for (int i = HIST_LEN - 1; i > 0; i--) hist_bytes[i] = hist_bytes[i-1];
    hist_bytes[0] = b;
    if (since_tail != dfd_pkg::COUNT_MAX) since_tail++;
    if (since_tail >= 4 && hist_bytes[3] == dfd_pkg::TAIL_B0 &&
        hist_bytes[2] == dfd_pkg::TAIL_B1 && hist_bytes[1] == dfd_pkg::TAIL_B2 &&
        hist_bytes[0] == dfd_pkg::TAIL_B3) begin
      payload_len = int'(since_tail) - 4;
      since_tail  = '0;
      nch = (int'(channel_count) > MAX_CH) ? MAX_CH : int'(channel_count);
      if (nch != 0 && payload_len >= nch * 4) begin
        for (int k = 0; k < nch; k++) begin
          cw.word = '0;
          for (int j = 0; j < 4; j++) begin
            // The earliest payload byte is farthest from the tail.
            pos = 4 + (nch * 4 - 1 - (k * 4 + j));
            cw.word[8*j +: 8] = hist_bytes[pos];
          end
          cw.index = INDEX_W'(k);
          cw.last  = (k + 1 == nch);
          expected_words = {expected_words, cw};
        end
      end
    end
  endfunction

  // Driver. A new byte is presented only when the channel holds none or the held one
  // was just taken, so the valid never looks at the stall and a stalled byte stays
  // put. The idle choice is a fresh draw every free cycle.
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        take_byte(data_byte);
        bytes_taken++;
      end
      if (!in_valid || !in_stall) begin
        if (pending_bytes.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          in_valid  <= 1'b1;
          data_byte <= pending_bytes.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor. Each output transaction is compared field by field with the oldest
  // predicted word; a word with nothing predicted is an error in its own right.
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_words.size() == 0) begin
          report_mismatch($sformatf("unexpected word %h index %0d last %b",
                                    channel_word, channel_index, last_word));
        end else begin
          head_word = expected_words.pop_front();
          if (channel_word !== head_word.word)
            report_mismatch($sformatf("word %0d: channel_word %h, predicted %h",
                                      words_checked, channel_word, head_word.word));
          if (channel_index !== head_word.index)
            report_mismatch($sformatf("word %0d: channel_index %0d, predicted %0d",
                                      words_checked, channel_index, head_word.index));
          if (last_word !== head_word.last)
            report_mismatch($sformatf("word %0d: last_word %b, predicted %b",
                                      words_checked, last_word, head_word.last));
        end
        words_checked++;
        if (last_word === 1'b1) frames_checked++;
      end
      out_stall <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  // The register changes only while the block is idle. The model takes the new value
  // at the edge where the write transaction completes.
  task automatic write_channel_count(input int value);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= CC_W'(value);
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    channel_count = CC_W'(value);
    cfg_valid <= 1'b0;
    settings_used++;
  endtask

  task automatic push_byte(input logic [BYTE_W-1:0] b);
    pending_bytes = {pending_bytes, b};
    bytes_queued++;
  endtask

  task automatic push_tail();
    push_byte(dfd_pkg::TAIL_B0);
    push_byte(dfd_pkg::TAIL_B1);
    push_byte(dfd_pkg::TAIL_B2);
    push_byte(dfd_pkg::TAIL_B3);
  endtask

  // Payload and noise bytes lean toward the tail bytes and the two extremes, so that
  // broken tails and partial matches turn up often.
  function automatic logic [BYTE_W-1:0] pick_byte();
    case ($urandom_range(9))
      0:       pick_byte = dfd_pkg::TAIL_B0;
      1:       pick_byte = dfd_pkg::TAIL_B2;
      2:       pick_byte = dfd_pkg::TAIL_B3;
      3:       pick_byte = 8'hFF;
      default: pick_byte = BYTE_W'($urandom_range(255));
    endcase
  endfunction

  task automatic push_frame(input int payload_len);
    for (int i = 0; i < payload_len; i++) push_byte(pick_byte());
    push_tail();
  endtask

  // Waits until every queued byte was taken and every predicted word came out. The
  // extra cycles cover a tail that is still on its way to the word chain.
  task automatic wait_drained();
    while (bytes_taken != bytes_queued) @(posedge clk);
    while (expected_words.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Mostly well-formed frames with random payloads, some frames whose payload is too
  // short, and some loose noise. With long_run set, the phase opens with a tail-free run
  // that, with the tail pushed after it, saturates the byte count.
  task automatic random_phase(input int cc_value, input bit long_run);
    int nch;
    int start;
    int pick;
    int len;
    logic [BYTE_W-1:0] b;
    nch   = (cc_value > MAX_CH) ? MAX_CH : cc_value;
    start = bytes_queued;
    if (long_run) begin
      for (int i = 0; i < LONG_RUN; i++) begin
        b = BYTE_W'($urandom_range(255));
        if (b == dfd_pkg::TAIL_B3) b = 8'h7E;
        push_byte(b);
      end
      push_frame(0);
    end
    while (bytes_queued - start < PHASE_BUDGET) begin
      pick = $urandom_range(99);
      if (pick < 70) begin
        len = (nch == 0) ? $urandom_range(8) : nch * 4 + $urandom_range(3);
        push_frame(len);
      end else if (pick < 85) begin
        len = (nch == 0) ? 0 : $urandom_range(nch * 4 - 1);
        push_frame(len);
      end else begin
        len = $urandom_range(1, 12);
        for (int i = 0; i < len; i++) push_byte(pick_byte());
      end
    end
  endtask

  initial begin
    clear_parser_model();
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // Under the reset count of twelve: a tail pattern that leans on history from
    // before reset is not a tail, and a tail with a two-byte payload is dropped.
    push_byte(dfd_pkg::TAIL_B2);
    push_byte(dfd_pkg::TAIL_B3);
    push_tail();
    wait_drained();

    // One channel: a word made of both byte extremes, then a tail right after a tail.
    write_channel_count(1);
    push_byte(8'h00);
    push_byte(8'hFF);
    push_byte(8'h00);
    push_byte(8'hFF);
    push_tail();
    push_tail();
    wait_drained();

    // Zero channels: the tail is consumed and nothing comes out.
    write_channel_count(0);
    push_byte(8'h12);
    push_tail();
    wait_drained();

    for (int p = 0; p < PHASES; p++) begin
      send_idle_pct  = phase_send[p];
      recv_stall_pct = phase_recv[p];
      write_channel_count(phase_cc[p]);
      random_phase(phase_cc[p], phase_cc[p] == MAX_CH);
      wait_drained();
    end

    send_idle_pct  = 0;
    recv_stall_pct = 0;
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (expected_words.size() != 0)
      report_mismatch($sformatf("%0d predicted words never came out",
                                expected_words.size()));

    $display("Sent %0d bytes under %0d channel-count writes, idle rates up to 61%%.",
             bytes_taken, settings_used);
    $display("Checked %0d channel words in %0d frames, %0d mismatches.",
             words_checked, frames_checked, mismatch_count);
    if (mismatch_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  // Guards against a hung handshake; the full run needs only a small part of this.
  initial begin
    #2_000_000;
    $display("Timeout: %0d of %0d bytes taken, %0d words still predicted.",
             bytes_taken, bytes_queued, expected_words.size());
    $display("*** FAILED ***");
    $finish;
  end

endmodule

### sim.f
src/dfd_pkg.sv
src/dfd_history.sv
src/dfd_word_cell.sv
src/tail_framed_float_deframer_unit.sv
dv/tail_framed_float_deframer_unit_test.sv
